FILE: hw/rtl/sae_pkg.sv
`default_nettype none

package sae_pkg;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch a sprite entry that passed the filter
        logic emit;     // write the current cell into the output register
    } sae_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pass;       // presented entry belongs to the selected pass
        logic last_cell;  // counters sit on the final cell of the grid
        logic out_free;   // output register can take a cell this cycle
    } sae_status_t;

    localparam int TileW   = 14;
    localparam int PosW    = 10;
    localparam int InDataW = 64;
    localparam int OutDataW = 40;

    localparam logic [12:0] TileSpecialA = 13'h3f8;
    localparam logic [12:0] TileSpecialB = 13'h3f9;

    // Tile offset of a column within the grid
    function automatic logic [4:0] col_off(input logic [2:0] c);
        logic [4:0] v;
        case (c)
            3'd0:    v = 5'd0;
            3'd1:    v = 5'd1;
            3'd2:    v = 5'd4;
            3'd3:    v = 5'd5;
            3'd4:    v = 5'd16;
            3'd5:    v = 5'd17;
            3'd6:    v = 5'd20;
            3'd7:    v = 5'd21;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // Tile offset of a row within the grid
    function automatic logic [5:0] row_off(input logic [2:0] r);
        logic [5:0] v;
        case (r)
            3'd0:    v = 6'd0;
            3'd1:    v = 6'd2;
            3'd2:    v = 6'd8;
            3'd3:    v = 6'd10;
            3'd4:    v = 6'd32;
            3'd5:    v = 6'd34;
            3'd6:    v = 6'd40;
            3'd7:    v = 6'd42;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    // Grid width minus one for a size code
    function automatic logic [2:0] width_m1(input logic [2:0] s);
        logic [2:0] v;
        case (s)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd1;
            3'd2:    v = 3'd0;
            3'd3:    v = 3'd1;
            3'd4:    v = 3'd3;
            3'd5:    v = 3'd1;
            3'd6:    v = 3'd3;
            3'd7:    v = 3'd7;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // Grid height minus one for a size code
    function automatic logic [2:0] height_m1(input logic [2:0] s);
        logic [2:0] v;
        case (s)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd0;
            3'd2:    v = 3'd1;
            3'd3:    v = 3'd1;
            3'd4:    v = 3'd1;
            3'd5:    v = 3'd3;
            3'd6:    v = 3'd3;
            3'd7:    v = 3'd7;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sae_ctrl.sv
`default_nettype none

module sae_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  sae_pkg::sae_status_t status,
    output sae_pkg::sae_cmd_t    cmd
);
    import sae_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Take a request in idle, then walk the grid one cell per free slot
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && status.pass)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_cell)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sae_datapath.sv
`default_nettype none

module sae_datapath (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             mode,
    input  wire  [sae_pkg::InDataW-1:0]     in_data,
    input  sae_pkg::sae_cmd_t               cmd,
    output sae_pkg::sae_status_t            status,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [sae_pkg::OutDataW-1:0]    out_data,
    output logic                            out_last
);
    import sae_pkg::*;

    // Entry bytes
    logic [7:0]  enable_byte;
    logic [7:0]  size_tile_high;
    logic [7:0]  tile_low;
    logic [7:0]  priority_color;
    logic [7:0]  y_high;
    logic [7:0]  y_low;
    logic [7:0]  x_high;
    logic [7:0]  x_low;

    assign enable_byte    = in_data[7:0];
    assign size_tile_high = in_data[15:8];
    assign tile_low       = in_data[23:16];
    assign priority_color = in_data[31:24];
    assign y_high         = in_data[39:32];
    assign y_low          = in_data[47:40];
    assign x_high         = in_data[55:48];
    assign x_low          = in_data[63:56];

    logic [12:0]     tile13;
    logic [1:0]      prio;
    logic [2:0]      size;
    logic [2:0]      wm1_in;
    logic [2:0]      hm1_in;
    logic            fx_in;
    logic            fy_in;
    logic [PosW-1:0] x0_in;
    logic [PosW-1:0] y0_in;
    logic [12:0]     base_in;
    logic            pass_in;
    logic            last_cell;
    logic            out_free;

    // Filter the entry for the selected pass
    assign tile13 = {size_tile_high[4:0], tile_low};
    assign prio   = priority_color[6:5];
    always_comb
    begin
        if (!enable_byte[7])
        begin
            pass_in = 1'b0;
        end
        else if (mode)
        begin
            pass_in = (prio == 2'd0);
        end
        else
        begin
            pass_in = (prio != 2'd0) || (tile13 == TileSpecialA)
                      || (tile13 == TileSpecialB);
        end
    end

    // Derive the grid origin and base tile
    assign size    = size_tile_high[7:5];
    assign wm1_in  = width_m1(size);
    assign hm1_in  = height_m1(size);
    assign fx_in   = x_high[1];
    assign fy_in   = y_high[1];
    assign base_in = (size != 3'd0) ? {tile13[12:2], 2'b00} : tile13;
    always_comb
    begin
        x0_in = {1'b0, x_high[0], x_low};
        y0_in = 10'd256 - {1'b0, y_high[0], y_low};
        if (fx_in)
        begin
            x0_in = x0_in + {3'd0, wm1_in, 4'd0};
        end
        if (fy_in)
        begin
            y0_in = y0_in + {3'd0, hm1_in, 4'd0};
        end
    end

    // Latched sprite attributes
    logic [12:0]     base_reg;
    logic [1:0]      color_reg;
    logic            fx_reg;
    logic            fy_reg;
    logic [PosW-1:0] x0_reg;
    logic [PosW-1:0] y0_reg;
    logic [2:0]      wm1_reg;
    logic [2:0]      hm1_reg;
    logic [2:0]      col_reg;
    logic [2:0]      col_next;
    logic [2:0]      row_reg;
    logic [2:0]      row_next;

    assign last_cell = (col_reg == wm1_reg) && (row_reg == hm1_reg);

    // Advance the cell counters, row by row
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load)
        begin
            col_next = 3'd0;
            row_next = 3'd0;
        end
        else if (cmd.emit)
        begin
            if (col_reg == wm1_reg)
            begin
                col_next = 3'd0;
                row_next = row_reg + 3'd1;
            end
            else
            begin
                col_next = col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg  <= base_in;
            color_reg <= priority_color[1:0];
            fx_reg    <= fx_in;
            fy_reg    <= fy_in;
            x0_reg    <= x0_in;
            y0_reg    <= y0_in;
            wm1_reg   <= wm1_in;
            hm1_reg   <= hm1_in;
        end
        col_reg <= col_next;
        row_reg <= row_next;
    end

    // Build the current cell
    logic [TileW-1:0] tile_cell;
    logic [PosW-1:0]  dx;
    logic [PosW-1:0]  dy;
    logic [PosW-1:0]  sx_cell;
    logic [PosW-1:0]  sy_cell;

    assign tile_cell = {1'b0, base_reg} + {9'd0, col_off(col_reg)}
                       + {8'd0, row_off(row_reg)};
    assign dx        = {3'd0, col_reg, 4'd0};
    assign dy        = {3'd0, row_reg, 4'd0};
    assign sx_cell   = fx_reg ? (x0_reg - dx) : (x0_reg + dx);
    assign sy_cell   = fy_reg ? (y0_reg - dy) : (y0_reg + dy);

    // Output register
    logic                valid_reg;
    logic [OutDataW-1:0] data_reg;
    logic                last_reg;

    assign out_free = !valid_reg || out_ready;

    // Report status to the controller
    assign status = '{pass: pass_in, last_cell: last_cell, out_free: out_free};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            data_reg <= {2'b00, sy_cell, sx_cell, fy_reg, fx_reg, color_reg, tile_cell};
            last_reg <= last_cell;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sprite_attribute_expander.sv
`default_nettype none

// Sprite attribute expander.
// The slave stream takes one 8-byte sprite entry per request, with the pass
// selector on tuser (1 = behind pass, 0 = front pass). A sprite that is
// disabled or filtered by priority produces nothing; its request is
// accepted and dropped. Otherwise it is split into a grid of 1x1 up to 8x8
// cells of 16x16 pixels, and the master stream carries one request per
// cell, row by row, with tlast on the final cell.
// An accepted entry is latched first; the first cell is then written into
// the output register, which drives the master stream.
// Throughput: one cell per cycle while the output register can take a
// cell, after the load of each entry. A new entry is accepted once the
// last cell has entered the output register, while that cell still waits
// to be taken.
// A stall on m_axis_tready holds the output register and the cell counters;
// no cell is lost or repeated.
// Reset clears the controller to idle and empties the output register.
module sprite_attribute_expander (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // enable_byte, size_tile_high, tile_low, priority_color,
    // y_high, y_low, x_high, x_low
    input  wire  [sae_pkg::InDataW-1:0]   s_axis_tdata,
    // mode
    input  wire                           s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // tile_number, color, flip_x, flip_y, screen_x, screen_y, 2 zero bits
    output logic [sae_pkg::OutDataW-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast
);
    import sae_pkg::*;

    sae_cmd_t    cmd;
    sae_status_t status;

    sae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sae_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
